### rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg: text console writer package
// Screen geometry, derived widths, action codes and controller states.
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = ROWS * COLUMNS;

	localparam int COL_W  = $clog2(COLUMNS);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int ADDR_W = $clog2(CELLS);
	localparam int CELL_W = 16;

	localparam logic [1:0] ACT_PUT   = 2'd0;
	localparam logic [1:0] ACT_CLEAR = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;

	localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
	localparam logic [7:0] SPACE_BYTE   = 8'h20;
	localparam logic [7:0] ATTR_RESET   = 8'h0F;

	typedef enum logic [2:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_ADDR,
		ST_ACCESS,
		ST_FILL,
		ST_RESP
	} state_t;

endpackage

### rtl/tcw_if.sv
// ----------------------------------------------------------------------------
// tcw_if: text console writer channels
// Command, response and attribute write channels with valid/ready.
// ----------------------------------------------------------------------------
interface tcw_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [7:0] char_byte;
	logic [4:0] read_row;
	logic [6:0] read_col;

	modport source(output valid, action, char_byte, read_row, read_col, input ready);
	modport sink(input valid, action, char_byte, read_row, read_col, output ready);
endinterface

interface tcw_rsp_if;
	logic        valid;
	logic        ready;
	logic [15:0] cell_value;
	logic [6:0]  cursor_col;
	logic [4:0]  cursor_row;
	logic        scrolled;

	modport source(output valid, cell_value, cursor_col, cursor_row, scrolled, input ready);
	modport sink(input valid, cell_value, cursor_col, cursor_row, scrolled, output ready);
endinterface

interface tcw_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] attribute;

	modport source(output valid, attribute, input ready);
	modport sink(input valid, attribute, output ready);
endinterface

### rtl/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram: simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
	parameter int DATA_W = 16,
	parameter int DEPTH  = 2000,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// tcw_ctrl: text console controller
// Cursor, ring-buffer row offset, sweep/fill sequencer and response register
// around the cell memory.
// ----------------------------------------------------------------------------
module tcw_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [7:0]       attr,
	tcw_cmd_if.sink          cmd,
	tcw_rsp_if.source        rsp
);

	localparam int AW = tcw_pkg::ADDR_W;
	localparam int CW = tcw_pkg::COL_W;
	localparam int RW = tcw_pkg::ROW_W;

	tcw_pkg::state_t state_q, state_d;

	logic [1:0]    act_q;
	logic [7:0]    char_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] prow_q;
	logic [AW-1:0] addr_q;
	logic          read_ok_q;
	logic          clr_item_q;
	logic          scroll_q;
	logic [AW-1:0] sweep_q;
	logic [CW-1:0] fill_cnt_q;
	logic [AW-1:0] fill_addr_q;
	logic [RW-1:0] top_q;
	logic [CW-1:0] cur_col_q;
	logic [RW-1:0] cur_row_q;

	logic          rsp_valid_q;
	logic [15:0]   rsp_cell_q;
	logic [6:0]    rsp_col_q;
	logic [4:0]    rsp_row_q;
	logic          rsp_scr_q;

	logic                            mem_we;
	logic [AW-1:0]                   mem_waddr;
	logic [tcw_pkg::CELL_W-1:0]      mem_wdata;
	logic                            mem_re;
	logic [tcw_pkg::CELL_W-1:0]      mem_rdata;

	logic          cmd_fire;
	logic          rsp_free;
	logic          is_nl;
	logic [CW:0]   col_inc;
	logic [RW:0]   row_inc;
	logic          wrap;
	logic [CW-1:0] nxt_col;
	logic [RW:0]   nxt_row_w;
	logic          do_scroll;
	logic [RW-1:0] nxt_row;
	logic          in_read_ok;
	logic [RW-1:0] in_row;
	logic [RW:0]   in_sum;
	logic [RW-1:0] in_prow;
	logic [RW-1:0] top_nxt;

	tcw_ram #(
		.DATA_W(tcw_pkg::CELL_W),
		.DEPTH (tcw_pkg::CELLS)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(addr_q),
		.rdata(mem_rdata)
	);

	assign cmd.ready  = (state_q == tcw_pkg::ST_IDLE);
	assign cmd_fire   = cmd.valid && cmd.ready;
	assign rsp_free   = !rsp_valid_q || rsp.ready;

	assign rsp.valid      = rsp_valid_q;
	assign rsp.cell_value = rsp_cell_q;
	assign rsp.cursor_col = rsp_col_q;
	assign rsp.cursor_row = rsp_row_q;
	assign rsp.scrolled   = rsp_scr_q;

	// cursor advance for a put
	assign is_nl     = (char_q == tcw_pkg::NEWLINE_BYTE);
	assign col_inc   = {1'b0, cur_col_q} + (CW+1)'(1);
	assign row_inc   = {1'b0, cur_row_q} + (RW+1)'(1);
	assign wrap      = is_nl || (col_inc == (CW+1)'(tcw_pkg::COLUMNS));
	assign nxt_col   = wrap ? '0 : col_inc[CW-1:0];
	assign nxt_row_w = wrap ? row_inc : {1'b0, cur_row_q};
	assign do_scroll = (nxt_row_w == (RW+1)'(tcw_pkg::ROWS));
	assign nxt_row   = do_scroll ? RW'(tcw_pkg::ROWS - 1) : nxt_row_w[RW-1:0];

	assign top_nxt = (top_q == RW'(tcw_pkg::ROWS - 1)) ? '0 : top_q + RW'(1);

	// map logical row onto the ring of physical rows
	assign in_read_ok = (32'(cmd.read_row) < tcw_pkg::ROWS) &&
	                    (32'(cmd.read_col) < tcw_pkg::COLUMNS);
	assign in_row  = (cmd.action == tcw_pkg::ACT_READ) ? RW'(cmd.read_row) : cur_row_q;
	assign in_sum  = {1'b0, in_row} + {1'b0, top_q};
	assign in_prow = (in_sum >= (RW+1)'(tcw_pkg::ROWS)) ?
	                 RW'(in_sum - (RW+1)'(tcw_pkg::ROWS)) : in_sum[RW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcw_pkg::ST_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = {attr, char_q};
		mem_re    = 1'b0;
		case (state_q)
			tcw_pkg::ST_SWEEP: begin
				mem_we    = 1'b1;
				mem_waddr = sweep_q;
				mem_wdata = '0;
				if (sweep_q == AW'(tcw_pkg::CELLS - 1)) begin
					state_d = clr_item_q ? tcw_pkg::ST_RESP : tcw_pkg::ST_IDLE;
				end
			end
			tcw_pkg::ST_IDLE: begin
				if (cmd_fire) begin
					case (cmd.action)
						tcw_pkg::ACT_PUT:   state_d = tcw_pkg::ST_ADDR;
						tcw_pkg::ACT_CLEAR: state_d = tcw_pkg::ST_SWEEP;
						tcw_pkg::ACT_READ: begin
							state_d = in_read_ok ? tcw_pkg::ST_ADDR : tcw_pkg::ST_RESP;
						end
						default:            state_d = tcw_pkg::ST_RESP;
					endcase
				end
			end
			tcw_pkg::ST_ADDR: begin
				state_d = tcw_pkg::ST_ACCESS;
			end
			tcw_pkg::ST_ACCESS: begin
				if (act_q == tcw_pkg::ACT_PUT) begin
					mem_we  = !is_nl;
					state_d = do_scroll ? tcw_pkg::ST_FILL : tcw_pkg::ST_RESP;
				end else begin
					mem_re  = 1'b1;
					state_d = tcw_pkg::ST_RESP;
				end
			end
			tcw_pkg::ST_FILL: begin
				mem_we    = 1'b1;
				mem_waddr = fill_addr_q;
				mem_wdata = {attr, tcw_pkg::SPACE_BYTE};
				if (fill_cnt_q == CW'(tcw_pkg::COLUMNS - 1)) begin
					state_d = tcw_pkg::ST_RESP;
				end
			end
			tcw_pkg::ST_RESP: begin
				if (rsp_free) begin
					state_d = tcw_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tcw_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_item_q  <= 1'b0;
			sweep_q     <= '0;
			top_q       <= '0;
			cur_col_q   <= '0;
			cur_row_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			case (state_q)
				tcw_pkg::ST_SWEEP: begin
					sweep_q <= sweep_q + AW'(1);
				end
				tcw_pkg::ST_IDLE: begin
					if (cmd_fire && cmd.action == tcw_pkg::ACT_CLEAR) begin
						clr_item_q <= 1'b1;
						sweep_q    <= '0;
						top_q      <= '0;
						cur_col_q  <= '0;
						cur_row_q  <= '0;
					end else if (cmd_fire) begin
						clr_item_q <= 1'b0;
					end
				end
				tcw_pkg::ST_ACCESS: begin
					if (act_q == tcw_pkg::ACT_PUT) begin
						cur_col_q <= nxt_col;
						cur_row_q <= nxt_row;
						if (do_scroll) begin
							top_q <= top_nxt;
						end
					end
				end
				default: begin
				end
			endcase

			if (state_q == tcw_pkg::ST_RESP && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			act_q     <= cmd.action;
			char_q    <= cmd.char_byte;
			col_q     <= (cmd.action == tcw_pkg::ACT_READ) ? CW'(cmd.read_col) : cur_col_q;
			prow_q    <= in_prow;
			read_ok_q <= (cmd.action == tcw_pkg::ACT_READ) && in_read_ok;
			scroll_q  <= 1'b0;
		end
		if (state_q == tcw_pkg::ST_ADDR) begin
			addr_q <= AW'(prow_q * tcw_pkg::COLUMNS) + AW'(col_q);
		end
		if (state_q == tcw_pkg::ST_ACCESS && act_q == tcw_pkg::ACT_PUT) begin
			scroll_q    <= do_scroll;
			// the old top row becomes the new bottom row
			fill_addr_q <= AW'(top_q * tcw_pkg::COLUMNS);
			fill_cnt_q  <= '0;
		end
		if (state_q == tcw_pkg::ST_FILL) begin
			fill_addr_q <= fill_addr_q + AW'(1);
			fill_cnt_q  <= fill_cnt_q + CW'(1);
		end
		if (state_q == tcw_pkg::ST_RESP && rsp_free) begin
			rsp_cell_q <= read_ok_q ? mem_rdata : '0;
			rsp_col_q  <= 7'(cur_col_q);
			rsp_row_q  <= 5'(cur_row_q);
			rsp_scr_q  <= scroll_q && !clr_item_q;
		end
	end

	a_wr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (32'(mem_waddr) < tcw_pkg::CELLS))
		else $error("cell write address beyond buffer");

	a_cursor_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(cur_col_q) < tcw_pkg::COLUMNS) && (32'(cur_row_q) < tcw_pkg::ROWS)
		&& (32'(top_q) < tcw_pkg::ROWS))
		else $error("cursor or top row out of range");

	a_scroll_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tcw_pkg::ST_FILL) |-> (cur_row_q == RW'(tcw_pkg::ROWS - 1)))
		else $error("scroll fill with cursor off the last row");

	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tcw_pkg::ST_IDLE || state_q == tcw_pkg::ST_RESP) |-> !mem_we && !mem_re)
		else $error("memory access outside a work state");

	a_resp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tcw_pkg::ST_RESP && !rsp_free) |=> (state_q == tcw_pkg::ST_RESP))
		else $error("result left while output register busy");

endmodule

### rtl/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer: text-mode console writer
// Puts characters into a rows by columns cell buffer, scrolls, clears and
// reads back cells.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake     | word
//  cmd      | in  | valid / ready | action, char_byte, read_row, read_col
//  rsp      | out | valid / ready | cell_value, cursor_col, cursor_row, scrolled
//  cfg      | in  | valid / ready | attribute (always ready)
//
// A put or in-range read passes through the dual-port cell memory in four steps
// (accept, address multiply, memory access, result). A scroll also fills the
// new bottom row; rows are kept as a ring so no copy runs.
// A clear sweeps every cell, ROWS*COLUMNS cells (2000 at 80x25).
// After reset the same sweep runs; cmd.ready stays low until it ends.
// A finished result waits in the output register; the next word is accepted
// meanwhile and stalls only at its own result stage.
// ----------------------------------------------------------------------------
module text_console_writer (
	input  logic      clk,
	input  logic      arst_n,
	tcw_cfg_if.sink   cfg,
	tcw_cmd_if.sink   cmd,
	tcw_rsp_if.source rsp
);

	logic [7:0] attr_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= tcw_pkg::ATTR_RESET;
		end else if (cfg.valid) begin
			attr_q <= cfg.attribute;
		end
	end

	tcw_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.attr  (attr_q),
		.cmd   (cmd),
		.rsp   (rsp)
	);

endmodule

### tb/sv/text_console_writer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_tb: self-checking bench for the text console writer
// Drives put, clear, read and unused commands with random idle and stall
// bursts, mirrors the screen, cursor and attribute in a local model, and
// checks every response word against the oldest prediction in order.
// ----------------------------------------------------------------------------
module text_console_writer_tb;

	localparam logic [1:0] ACT_SPARE = 2'd3;
	localparam int WATCHDOG_CYCLES = 10000;
	localparam int SETTLE_CYCLES   = 50;

	typedef struct packed {
		logic [15:0] cell_value;
		logic [6:0]  cursor_col;
		logic [4:0]  cursor_row;
		logic        scrolled;
	} console_reply_t;

	logic clk;
	logic arst_n;

	tcw_cfg_if cfg();
	tcw_cmd_if cmd();
	tcw_rsp_if rsp();

	text_console_writer dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.cmd(cmd),
		.rsp(rsp)
	);

	// screen mirror
	logic [15:0]    screen [tcw_pkg::ROWS][tcw_pkg::COLUMNS];
	int unsigned    crow;
	int unsigned    ccol;
	logic [7:0]     attr_shadow;
	console_reply_t due_replies[$];

	int unsigned mismatch_count;
	int unsigned quiet_cycles;
	int unsigned stall_left;
	bit          bursts_on;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void blank_screen();
		for (int r = 0; r < tcw_pkg::ROWS; r++)
			for (int c = 0; c < tcw_pkg::COLUMNS; c++)
				screen[r][c] = 16'h0000;
		crow = 0;
		ccol = 0;
	endfunction

	function automatic void apply_console_word(input logic [1:0] act, input logic [7:0] ch,
			input logic [4:0] rr, input logic [6:0] rc);
		console_reply_t reply;
		reply = '0;
		if (act == tcw_pkg::ACT_PUT) begin
			if (ch == tcw_pkg::NEWLINE_BYTE) begin
				ccol = 0;
				crow++;
			end else begin
				screen[crow][ccol] = {attr_shadow, ch};
				ccol++;
			end
			if (ccol >= tcw_pkg::COLUMNS) begin
				ccol = 0;
				crow++;
			end
			if (crow >= tcw_pkg::ROWS) begin
				// shift rows up, fill bottom with spaces
				for (int r = 0; r < tcw_pkg::ROWS - 1; r++)
					for (int c = 0; c < tcw_pkg::COLUMNS; c++)
						screen[r][c] = screen[r + 1][c];
				for (int c = 0; c < tcw_pkg::COLUMNS; c++)
					screen[tcw_pkg::ROWS - 1][c] = {attr_shadow, tcw_pkg::SPACE_BYTE};
				crow = tcw_pkg::ROWS - 1;
				reply.scrolled = 1'b1;
			end
		end else if (act == tcw_pkg::ACT_CLEAR) begin
			blank_screen();
		end else if (act == tcw_pkg::ACT_READ) begin
			if (rr < tcw_pkg::ROWS && rc < tcw_pkg::COLUMNS)
				reply.cell_value = screen[rr][rc];
		end
		reply.cursor_col = ccol[6:0];
		reply.cursor_row = crow[4:0];
		due_replies.push_back(reply);
	endfunction

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $time, what);
		mismatch_count++;
	endtask

	// response checker
	always @(posedge clk) begin
		console_reply_t want;
		if (arst_n && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
			if (due_replies.size() == 0) begin
				report_mismatch("response word with nothing outstanding");
			end else begin
				want = due_replies.pop_front();
				if (rsp.cell_value !== want.cell_value)
					report_mismatch($sformatf("cell_value got %h want %h",
						rsp.cell_value, want.cell_value));
				if (rsp.cursor_col !== want.cursor_col)
					report_mismatch($sformatf("cursor_col got %0d want %0d",
						rsp.cursor_col, want.cursor_col));
				if (rsp.cursor_row !== want.cursor_row)
					report_mismatch($sformatf("cursor_row got %0d want %0d",
						rsp.cursor_row, want.cursor_row));
				if (rsp.scrolled !== want.scrolled)
					report_mismatch($sformatf("scrolled got %b want %b",
						rsp.scrolled, want.scrolled));
			end
		end
	end

	// response stall bursts
	always @(negedge clk) begin
		if (!bursts_on) begin
			rsp.ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			rsp.ready <= 1'b0;
		end else if ($urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(1, 14) - 1;
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= 1'b1;
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((cmd.valid === 1'b1 && cmd.ready === 1'b1) ||
				(rsp.valid === 1'b1 && rsp.ready === 1'b1) ||
				(cfg.valid === 1'b1 && cfg.ready === 1'b1)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_CYCLES) begin
				$display("watchdog expired at %0t", $time);
				$display("text_console_writer_tb: FAIL");
				$finish;
			end
		end
	end

	task automatic send_word(input logic [1:0] act, input logic [7:0] ch,
			input logic [4:0] rr, input logic [6:0] rc);
		@(negedge clk);
		if (bursts_on && $urandom_range(0, 4) == 0) begin
			cmd.valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		cmd.valid     <= 1'b1;
		cmd.action    <= act;
		cmd.char_byte <= ch;
		cmd.read_row  <= rr;
		cmd.read_col  <= rc;
		@(posedge clk);
		while (cmd.ready !== 1'b1)
			@(posedge clk);
		apply_console_word(act, ch, rr, rc);
	endtask

	// hold the command channel until every reply is back
	task automatic drain_replies();
		@(negedge clk);
		cmd.valid <= 1'b0;
		while (due_replies.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_attribute(input logic [7:0] value);
		drain_replies();
		@(negedge clk);
		cfg.valid     <= 1'b1;
		cfg.attribute <= value;
		@(posedge clk);
		while (cfg.ready !== 1'b1)
			@(posedge clk);
		attr_shadow = value;
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic send_random_word(input int unsigned newline_pct, input bit allow_clear);
		int unsigned pick;
		logic [1:0]  act;
		logic [7:0]  ch;
		logic [4:0]  rr;
		logic [6:0]  rc;
		pick = $urandom_range(0, 99);
		ch   = 8'($urandom_range(0, 255));
		rr   = 5'($urandom);
		rc   = 7'($urandom);
		if (allow_clear && pick < 1) begin
			act = tcw_pkg::ACT_CLEAR;
		end else if (pick < 3) begin
			act = ACT_SPARE;
		end else if (pick < 25) begin
			act = tcw_pkg::ACT_READ;
			// mostly in range, often on the cursor row
			if ($urandom_range(0, 7) != 0) begin
				rr = 5'($urandom_range(0, tcw_pkg::ROWS - 1));
				rc = 7'($urandom_range(0, tcw_pkg::COLUMNS - 1));
				if ($urandom_range(0, 1) == 0)
					rr = crow[4:0];
			end
		end else begin
			act = tcw_pkg::ACT_PUT;
			if ($urandom_range(0, 99) < newline_pct)
				ch = tcw_pkg::NEWLINE_BYTE;
		end
		send_word(act, ch, rr, rc);
	endtask

	task automatic test_reset_contents();
		send_word(tcw_pkg::ACT_READ, 8'h00, 5'd0, 7'd0);
		send_word(tcw_pkg::ACT_READ, 8'h00, 5'(tcw_pkg::ROWS - 1), 7'(tcw_pkg::COLUMNS - 1));
		send_word(tcw_pkg::ACT_READ, 8'h00, 5'd12, 7'd40);
	endtask

	task automatic test_directed_actions();
		send_word(tcw_pkg::ACT_PUT, 8'h00, 5'd0, 7'd0);
		send_word(tcw_pkg::ACT_PUT, 8'hFF, 5'd31, 7'd127);
		send_word(tcw_pkg::ACT_PUT, 8'hAA, 5'd0, 7'd0);
		send_word(tcw_pkg::ACT_PUT, 8'h55, 5'd31, 7'd127);
		for (int c = 0; c < 4; c++)
			send_word(tcw_pkg::ACT_READ, 8'h00, 5'd0, 7'(c));
		send_word(tcw_pkg::ACT_READ, 8'h00, 5'(tcw_pkg::ROWS - 1), 7'(tcw_pkg::COLUMNS - 1));
		send_word(tcw_pkg::ACT_READ, 8'h00, 5'(tcw_pkg::ROWS), 7'd0);
		send_word(tcw_pkg::ACT_READ, 8'h00, 5'd0, 7'(tcw_pkg::COLUMNS));
		send_word(tcw_pkg::ACT_READ, 8'hFF, 5'd31, 7'd127);
		send_word(ACT_SPARE, 8'hFF, 5'd31, 7'd127);
		send_word(tcw_pkg::ACT_PUT, tcw_pkg::NEWLINE_BYTE, 5'd0, 7'd0);
		send_word(tcw_pkg::ACT_PUT, 8'h41, 5'd0, 7'd0);
		send_word(tcw_pkg::ACT_READ, 8'h00, 5'd1, 7'd0);
		send_word(tcw_pkg::ACT_CLEAR, 8'hFF, 5'd31, 7'd127);
		send_word(tcw_pkg::ACT_READ, 8'h00, 5'd0, 7'd0);
		send_word(tcw_pkg::ACT_READ, 8'h00, 5'd1, 7'd0);
	endtask

	task automatic test_line_wrap();
		logic [7:0] ch;
		for (int i = 0; i < 2 * tcw_pkg::COLUMNS + 5; i++) begin
			ch = 8'($urandom_range(0, 255));
			if (ch == tcw_pkg::NEWLINE_BYTE)
				ch = 8'h0B;
			send_word(tcw_pkg::ACT_PUT, ch, 5'($urandom), 7'($urandom));
		end
		for (int i = 0; i < 8; i++)
			send_word(tcw_pkg::ACT_READ, 8'h00, 5'($urandom_range(0, 3)),
				7'($urandom_range(0, tcw_pkg::COLUMNS - 1)));
	endtask

	task automatic test_scroll_last_row();
		logic [7:0] ch;
		send_word(tcw_pkg::ACT_CLEAR, 8'h00, 5'd0, 7'd0);
		for (int i = 0; i < tcw_pkg::ROWS - 1; i++)
			send_word(tcw_pkg::ACT_PUT, tcw_pkg::NEWLINE_BYTE, 5'($urandom), 7'($urandom));
		// newline on the bottom row scrolls
		send_word(tcw_pkg::ACT_PUT, tcw_pkg::NEWLINE_BYTE, 5'd0, 7'd0);
		for (int i = 0; i < tcw_pkg::COLUMNS + 5; i++) begin
			ch = 8'($urandom_range(0, 255));
			if (ch == tcw_pkg::NEWLINE_BYTE)
				ch = 8'h7E;
			send_word(tcw_pkg::ACT_PUT, ch, 5'($urandom), 7'($urandom));
		end
		for (int i = 0; i < 8; i++)
			send_word(tcw_pkg::ACT_READ, 8'h00,
				5'($urandom_range(tcw_pkg::ROWS - 2, tcw_pkg::ROWS - 1)),
				7'($urandom_range(0, tcw_pkg::COLUMNS - 1)));
	endtask

	task automatic test_attribute_sweep();
		logic [7:0] attrs [5];
		attrs = '{8'h00, 8'hFF, 8'hA5, 8'h5A, 8'h00};
		attrs[4] = 8'($urandom_range(0, 255));
		foreach (attrs[k]) begin
			write_attribute(attrs[k]);
			for (int i = 0; i < 40; i++)
				send_random_word(20, 1'b0);
		end
	endtask

	task automatic test_random_traffic();
		for (int i = 0; i < 400; i++) begin
			if (i == 130 || i == 300)
				write_attribute(8'($urandom_range(0, 255)));
			if (i == 200)
				drain_replies();
			send_random_word(12, 1'b1);
		end
	endtask

	task automatic test_no_idle_tail();
		bursts_on = 1'b0;
		for (int i = 0; i < 100; i++)
			send_random_word(12, 1'b1);
	endtask

	initial begin
		arst_n         = 1'b0;
		cmd.valid      = 1'b0;
		cmd.action     = tcw_pkg::ACT_PUT;
		cmd.char_byte  = 8'h00;
		cmd.read_row   = 5'd0;
		cmd.read_col   = 7'd0;
		cfg.valid      = 1'b0;
		cfg.attribute  = tcw_pkg::ATTR_RESET;
		rsp.ready      = 1'b0;
		mismatch_count = 0;
		quiet_cycles   = 0;
		stall_left     = 0;
		bursts_on      = 1'b1;
		attr_shadow    = tcw_pkg::ATTR_RESET;
		blank_screen();
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		test_reset_contents();
		test_directed_actions();
		test_line_wrap();
		test_scroll_last_row();
		test_attribute_sweep();
		test_random_traffic();
		test_no_idle_tail();

		drain_replies();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("text_console_writer_tb: PASS");
		end else begin
			$display("text_console_writer_tb: FAIL");
		end
		$finish;
	end

endmodule
